### design/isu_pkg.sv
// Shared types and constants for the interval set union insert block.
package isu_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int TIME_BITS_DEF = 32;
  localparam int OP_W          = 2;
  localparam int INDEX_W       = 6;
  localparam int STATUS_W      = 2;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // Command broadcast to every cell
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_CMP,
    CMD_INS,
    CMD_MERGE,
    CMD_COLL
  } cell_cmd_t;

  // Per-cell classification against the interval being inserted
  typedef struct packed {
    logic below;
    logic ovl;
    logic above;
    logic dead;
  } cell_flag_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_APPLY,
    S_COLL
  } isu_state_t;

endpackage

### design/isu_cell.sv
// One table slot: holds an interval and its flags, moves data to and from its neighbors.
module isu_cell #(
  parameter int TW = isu_pkg::TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  isu_pkg::cell_cmd_t    cmd,
  input  logic                  valid_i,
  input  logic [TW-1:0]         new_start,
  input  logic [TW-1:0]         new_end,
  input  logic [TW-1:0]         merge_end,
  input  logic [TW-1:0]         l_start,
  input  logic [TW-1:0]         l_end,
  input  isu_pkg::cell_flag_t   l_flg,
  input  logic [TW-1:0]         r_start,
  input  logic [TW-1:0]         r_end,
  input  isu_pkg::cell_flag_t   r_flg,
  output logic [TW-1:0]         start_q,
  output logic [TW-1:0]         end_q,
  output isu_pkg::cell_flag_t   flg_q
);

  logic [TW-1:0]       start_r, start_nxt;
  logic [TW-1:0]       end_r, end_nxt;
  isu_pkg::cell_flag_t flg_r, flg_nxt;

  // Local update rule
  always_comb begin
    start_nxt = start_r;
    end_nxt   = end_r;
    flg_nxt   = flg_r;
    case (cmd)
      isu_pkg::CMD_CMP: begin
        flg_nxt.below = valid_i && (end_r < new_start);
        flg_nxt.ovl   = valid_i && (end_r >= new_start) && (start_r <= new_end);
        flg_nxt.above = valid_i && (start_r > new_end);
        flg_nxt.dead  = 1'b0;
      end
      isu_pkg::CMD_INS: begin
        // open a gap at the first slot not below the new interval
        if (!flg_r.below) begin
          if (l_flg.below) begin
            start_nxt = new_start;
            end_nxt   = new_end;
          end else begin
            start_nxt = l_start;
            end_nxt   = l_end;
          end
        end
      end
      isu_pkg::CMD_MERGE: begin
        if (flg_r.ovl && !l_flg.ovl) begin
          start_nxt = (start_r < new_start) ? start_r : new_start;
          end_nxt   = merge_end;
        end else if (flg_r.ovl) begin
          flg_nxt.dead = 1'b1;
        end
      end
      isu_pkg::CMD_COLL: begin
        // close one dead slot per cycle
        if (flg_r.dead || flg_r.above) begin
          start_nxt     = r_start;
          end_nxt       = r_end;
          flg_nxt.dead  = r_flg.dead;
          flg_nxt.above = r_flg.above;
        end
      end
      default: begin
      end
    endcase
  end

  // Interval payload
  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    end_r   <= end_nxt;
  end

  // Flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flg_r <= '0;
    end else begin
      flg_r <= flg_nxt;
    end
  end

  assign start_q = start_r;
  assign end_q   = end_r;
  assign flg_q   = flg_r;

endmodule

### design/interval_set_union_insert.sv
// Top level: sorted table of disjoint closed intervals with coalescing insert.
// The table is a row of CAPACITY cells, one interval each, kept sorted by start.
// Each transaction is taken in the idle state; a stalled output holds the
// sequencer before the result is posted. A read, a clear or an unused opcode
// posts its result from the execute state. An insert that touches no entry
// classifies every cell against the new interval, then opens a slot by shifting
// the upper cells right and posts the result (a full table posts ST_FULL
// instead), then goes idle. An insert that coalesces k entries classifies,
// writes the merged entry in place, shifts the row left one slot per cycle to
// close the k - 1 freed slots, posts the result, then goes idle. One
// transaction is in work at a time; a finished result waits in the output
// register and a new transaction may be taken meanwhile.
module interval_set_union_insert #(
  parameter int CAPACITY  = isu_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = isu_pkg::TIME_BITS_DEF,
  localparam int CW       = $clog2(CAPACITY + 1),
  localparam int IN_BITS  = isu_pkg::OP_W + 2 * TIME_BITS + isu_pkg::INDEX_W,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 2 * TIME_BITS + CW + isu_pkg::STATUS_W,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // op, start_minute, end_minute, index
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // out_start, out_end, count, status
);

  localparam int TW = TIME_BITS;

  // Input field unpack
  logic [isu_pkg::OP_W-1:0]    in_op;
  logic [TW-1:0]               in_start;
  logic [TW-1:0]               in_end;
  logic [isu_pkg::INDEX_W-1:0] in_index;

  assign in_op    = in_tdata[0 +: isu_pkg::OP_W];
  assign in_start = in_tdata[isu_pkg::OP_W +: TW];
  assign in_end   = in_tdata[isu_pkg::OP_W + TW +: TW];
  assign in_index = in_tdata[isu_pkg::OP_W + 2 * TW +: isu_pkg::INDEX_W];

  // Transaction held during work
  isu_pkg::isu_state_t         state_r, state_nxt;
  logic [isu_pkg::OP_W-1:0]    op_r;
  logic [TW-1:0]               s_r, e_r;
  logic [isu_pkg::INDEX_W-1:0] index_r;
  logic [CW-1:0]               count_r, count_nxt;

  // Output register
  logic                         out_valid_r;
  logic [TW-1:0]                out_start_r, out_end_r;
  logic [CW-1:0]                out_count_r;
  logic [isu_pkg::STATUS_W-1:0] out_status_r;

  // Cell row wiring
  isu_pkg::cell_cmd_t  cmd;
  logic [TW-1:0]       c_start [CAPACITY];
  logic [TW-1:0]       c_end   [CAPACITY];
  isu_pkg::cell_flag_t c_flg   [CAPACITY];
  logic [TW-1:0]       merge_end;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [TW-1:0]       l_start_w, l_end_w, r_start_w, r_end_w;
      isu_pkg::cell_flag_t l_flg_w, r_flg_w;
      logic                valid_w;

      if (gi == 0) begin : g_first
        assign l_start_w = '0;
        assign l_end_w   = '0;
        assign l_flg_w   = '{below: 1'b1, ovl: 1'b0, above: 1'b0, dead: 1'b0};
      end else begin : g_mid_l
        assign l_start_w = c_start[gi-1];
        assign l_end_w   = c_end[gi-1];
        assign l_flg_w   = c_flg[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign r_start_w = '0;
        assign r_end_w   = '0;
        assign r_flg_w   = '0;
      end else begin : g_mid_r
        assign r_start_w = c_start[gi+1];
        assign r_end_w   = c_end[gi+1];
        assign r_flg_w   = c_flg[gi+1];
      end

      assign valid_w = (count_r > CW'(gi));

      isu_cell #(.TW(TW)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .valid_i   (valid_w),
        .new_start (s_r),
        .new_end   (e_r),
        .merge_end (merge_end),
        .l_start   (l_start_w),
        .l_end     (l_end_w),
        .l_flg     (l_flg_w),
        .r_start   (r_start_w),
        .r_end     (r_end_w),
        .r_flg     (r_flg_w),
        .start_q   (c_start[gi]),
        .end_q     (c_end[gi]),
        .flg_q     (c_flg[gi])
      );
    end
  endgenerate

  // Row-wide views: overlap edges, end of last overlapped entry, read select
  logic [CAPACITY-1:0] first_o, last_o, dead_v;
  logic [TW-1:0]       last_end, rd_start, rd_end;
  logic                any_o, any_dead;

  always_comb begin
    last_end = '0;
    rd_start = '0;
    rd_end   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      first_o[i] = c_flg[i].ovl && !((i > 0) && c_flg[(i > 0) ? i - 1 : 0].ovl);
      last_o[i]  = c_flg[i].ovl &&
                   !((i < CAPACITY - 1) && c_flg[(i < CAPACITY - 1) ? i + 1 : i].ovl);
      dead_v[i]  = c_flg[i].dead;
      if (last_o[i]) begin
        last_end = last_end | c_end[i];
      end
      if (int'(index_r) == i) begin
        rd_start = rd_start | c_start[i];
        rd_end   = rd_end | c_end[i];
      end
    end
    any_o     = |first_o;
    any_dead  = |dead_v;
    merge_end = (last_end > e_r) ? last_end : e_r;
  end

  logic out_free;
  logic rd_ok;
  assign out_free = !out_valid_r || out_tready;
  assign rd_ok    = ({{(CW > isu_pkg::INDEX_W ? CW - isu_pkg::INDEX_W : 0){1'b0}}, index_r}
                     < (CW > isu_pkg::INDEX_W ? CW : isu_pkg::INDEX_W)'(count_r));

  // Sequencer: next state, cell command, result
  logic                         res_valid;
  logic [TW-1:0]                res_start, res_end;
  logic [isu_pkg::STATUS_W-1:0] res_status;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    cmd        = isu_pkg::CMD_HOLD;
    res_valid  = 1'b0;
    res_start  = '0;
    res_end    = '0;
    res_status = isu_pkg::ST_OK;
    case (state_r)
      isu_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = isu_pkg::S_EXEC;
        end
      end
      isu_pkg::S_EXEC: begin
        if (op_r == isu_pkg::OP_INSERT) begin
          cmd       = isu_pkg::CMD_CMP;
          state_nxt = isu_pkg::S_APPLY;
        end else if (out_free) begin
          res_valid = 1'b1;
          state_nxt = isu_pkg::S_IDLE;
          if (op_r == isu_pkg::OP_READ) begin
            if (rd_ok) begin
              res_start = rd_start;
              res_end   = rd_end;
            end else begin
              res_status = isu_pkg::ST_RANGE;
            end
          end else if (op_r == isu_pkg::OP_CLEAR) begin
            count_nxt = '0;
          end
        end
      end
      isu_pkg::S_APPLY: begin
        if (any_o) begin
          cmd       = isu_pkg::CMD_MERGE;
          state_nxt = isu_pkg::S_COLL;
        end else if (out_free) begin
          res_valid = 1'b1;
          state_nxt = isu_pkg::S_IDLE;
          if (count_r == CW'(CAPACITY)) begin
            res_status = isu_pkg::ST_FULL;
          end else begin
            cmd       = isu_pkg::CMD_INS;
            count_nxt = count_r + 1'b1;
          end
        end
      end
      isu_pkg::S_COLL: begin
        if (any_dead) begin
          cmd       = isu_pkg::CMD_COLL;
          count_nxt = count_r - 1'b1;
        end else if (out_free) begin
          res_valid = 1'b1;
          state_nxt = isu_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = isu_pkg::S_IDLE;
      end
    endcase
  end

  assign in_tready = (state_r == isu_pkg::S_IDLE);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= isu_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Accepted transaction; interval stored in ascending order
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r    <= in_op;
      index_r <= in_index;
      s_r     <= (in_end < in_start) ? in_end : in_start;
      e_r     <= (in_end < in_start) ? in_start : in_end;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_start_r  <= res_start;
      out_end_r    <= res_end;
      out_count_r  <= count_nxt;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_status_r, out_count_r, out_end_r, out_start_r});

`ifndef NO_ASSERTIONS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_coll_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == isu_pkg::S_COLL && any_dead) |=> (count_r == $past(count_r) - 1'b1))
    else $error("collapse step did not drop count by one");

  a_merge_coll: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == isu_pkg::S_APPLY && any_o) |=> (state_r == isu_pkg::S_COLL))
    else $error("merge not followed by collapse");

  a_one_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == isu_pkg::S_APPLY) |-> $onehot0(first_o))
    else $error("overlapped entries not contiguous");
`endif

endmodule
